/* design/cbc_pkg.sv */
// Shared types, sizes and codes of the cartridge bank controller.
`default_nettype none
package cbc_pkg;

	localparam int ROM_MAX_BYTES = 2097152;
	localparam int RAM_MAX_BYTES = 32768;

	localparam int ROM_AW = $clog2(ROM_MAX_BYTES);
	localparam int RAM_AW = $clog2(RAM_MAX_BYTES);
	localparam int ROM_LIM_W = 22;
	localparam int RAM_LIM_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [ROM_LIM_W-1:0] ROM_MAX = ROM_LIM_W'(ROM_MAX_BYTES);
	localparam logic [RAM_LIM_W-1:0] RAM_MAX = RAM_LIM_W'(RAM_MAX_BYTES);
	localparam logic [ROM_LIM_W-1:0] LARGE_ROM_LIMIT = ROM_LIM_W'(512 * 1024);
	localparam logic [ROM_LIM_W-1:0] ROM_BYTES_RESET = ROM_LIM_W'(32768);
	localparam logic [RAM_AW-1:0] CLEAR_LAST = RAM_AW'(RAM_MAX_BYTES - 1);

	localparam logic [7:0] OPEN_BUS = 8'hFF;
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES = 2'd1;

	typedef enum logic [2:0] {
		CMD_ROM_READ   = 3'd0,
		CMD_CTRL_WRITE = 3'd1,
		CMD_RAM_READ   = 3'd2,
		CMD_RAM_WRITE  = 3'd3,
		CMD_ROM_LOAD   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_RAM_ENABLE = 2'd0,
		REG_ROM_BANK   = 2'd1,
		REG_UPPER_BANK = 2'd2,
		REG_BANK_MODE  = 2'd3
	} ctrl_reg_t;

	typedef enum logic [1:0] {
		SRC_ECHO = 2'd0,
		SRC_ROM  = 2'd1,
		SRC_RAM  = 2'd2
	} src_t;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	typedef struct packed {
		logic              rom_rd;
		logic              rom_wr;
		logic [ROM_AW-1:0] rom_addr;
		logic              ram_rd;
		logic              ram_wr;
		logic [RAM_AW-1:0] ram_addr;
		src_t              src;
		logic [7:0]        echo_data;
		logic              open;
	} req_t;

endpackage
`default_nettype wire

/* design/cbc_map.sv */
// Bank and size registers with the address translation of one bus access.
`default_nettype none
module cbc_map (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cbc_pkg::ROM_LIM_W-1:0]   cfg_data,
	input  wire logic                            accept,
	input  wire logic [2:0]                      cmd,
	input  wire logic [14:0]                     address,
	input  wire logic [20:0]                     load_offset,
	input  wire logic [7:0]                      write_data,
	output cbc_pkg::req_t                        req
);

	logic [cbc_pkg::ROM_LIM_W-1:0] rom_bytes_q;
	logic [cbc_pkg::RAM_LIM_W-1:0] ram_bytes_q;
	logic                          ram_enabled_q;
	logic [4:0]                    low_rom_bank_q;
	logic [1:0]                    upper_bank_q;
	logic                          bank_mode_q;

	logic [cbc_pkg::ROM_LIM_W-1:0] rom_lim;
	logic [cbc_pkg::RAM_LIM_W-1:0] ram_lim;
	logic                          big_rom;
	logic [6:0]                    rom_bank;
	logic [1:0]                    ram_bank;
	logic [cbc_pkg::ROM_AW-1:0]    rom_off;
	logic [cbc_pkg::RAM_AW-1:0]    ram_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bytes_q <= cbc_pkg::ROM_BYTES_RESET;
			ram_bytes_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == cbc_pkg::CFG_ROM_BYTES) begin
				rom_bytes_q <= cfg_data;
			end else if (cfg_index == cbc_pkg::CFG_RAM_BYTES) begin
				ram_bytes_q <= cfg_data[cbc_pkg::RAM_LIM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q  <= 1'b0;
			low_rom_bank_q <= 5'd1;
			upper_bank_q   <= 2'd0;
			bank_mode_q    <= 1'b0;
		end else if (accept && cmd == cbc_pkg::CMD_CTRL_WRITE) begin
			case (cbc_pkg::ctrl_reg_t'(address[14:13]))
				cbc_pkg::REG_RAM_ENABLE: begin
					ram_enabled_q <= (write_data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
				end
				cbc_pkg::REG_ROM_BANK: begin
					low_rom_bank_q <= (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
				end
				cbc_pkg::REG_UPPER_BANK: begin
					upper_bank_q <= write_data[1:0];
				end
				default: begin
					bank_mode_q <= write_data[0];
				end
			endcase
		end
	end

	always_comb begin
		rom_lim = (rom_bytes_q > cbc_pkg::ROM_MAX) ? cbc_pkg::ROM_MAX : rom_bytes_q;
		ram_lim = (ram_bytes_q > cbc_pkg::RAM_MAX) ? cbc_pkg::RAM_MAX : ram_bytes_q;
		big_rom = (rom_lim > cbc_pkg::LARGE_ROM_LIMIT);

		if (!address[14]) begin
			rom_bank = (bank_mode_q && big_rom) ? {upper_bank_q, 5'd0} : 7'd0;
		end else begin
			rom_bank = {(big_rom ? upper_bank_q : 2'd0), low_rom_bank_q};
		end
		rom_off  = {rom_bank, address[13:0]};
		ram_bank = (bank_mode_q && !big_rom) ? upper_bank_q : 2'd0;
		ram_off  = {ram_bank, address[12:0]};
	end

	always_comb begin
		req           = '0;
		req.rom_addr  = rom_off;
		req.ram_addr  = ram_off;
		req.src       = cbc_pkg::SRC_ECHO;
		req.echo_data = cbc_pkg::OPEN_BUS;
		req.open      = 1'b1;
		case (cmd)
			cbc_pkg::CMD_ROM_READ: begin
				if ({1'b0, rom_off} < rom_lim) begin
					req.rom_rd = 1'b1;
					req.src    = cbc_pkg::SRC_ROM;
					req.open   = 1'b0;
				end
			end
			cbc_pkg::CMD_RAM_READ: begin
				if (ram_enabled_q && {1'b0, ram_off} < ram_lim) begin
					req.ram_rd = 1'b1;
					req.src    = cbc_pkg::SRC_RAM;
					req.open   = 1'b0;
				end
			end
			cbc_pkg::CMD_RAM_WRITE: begin
				if (ram_enabled_q && {1'b0, ram_off} < ram_lim) begin
					req.ram_wr    = 1'b1;
					req.echo_data = write_data;
					req.open      = 1'b0;
				end
			end
			cbc_pkg::CMD_ROM_LOAD: begin
				req.rom_addr = load_offset;
				if ({1'b0, load_offset} < cbc_pkg::ROM_MAX) begin
					req.rom_wr    = 1'b1;
					req.echo_data = write_data;
					req.open      = 1'b0;
				end
			end
			default: begin
				req.open = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/cartridge_bank_controller_core.sv */
// Top level of the cartridge bank controller: memories, result pipeline and RAM clear.
// A result is registered in stage s1 and then in the output register after its input beat is accepted.
// Throughput: one beat per cycle while out_stall is low, set by one access per cycle to the ROM or RAM port.
// Reset sets the bank and size registers to their reset values at once and then runs a clearing
// pass over all 32768 bytes of the RAM, one byte a cycle, while in_stall stays high.
// ROM contents are kept across reset; configuration writes are taken at any time.
`default_nettype none
module cartridge_bank_controller_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [2:0]                      cmd,
	input  wire logic [14:0]                     address,
	input  wire logic [20:0]                     load_offset,
	input  wire logic [7:0]                      write_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           read_data,
	output logic                                 open_bus,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cbc_pkg::ROM_LIM_W-1:0]   cfg_data
);

	cbc_pkg::req_t   req;
	cbc_pkg::state_t state_q;
	cbc_pkg::state_t state_d;

	logic                       accept;
	logic                       running;
	logic                       clr_we;
	logic [cbc_pkg::RAM_AW-1:0] clr_cnt_q;

	logic [7:0] rom_mem [cbc_pkg::ROM_MAX_BYTES];
	logic [7:0] ram_mem [cbc_pkg::RAM_MAX_BYTES];
	logic [7:0] rom_rdata_s1;
	logic [7:0] ram_rdata_s1;

	logic          valid_s1;
	cbc_pkg::src_t src_s1;
	logic [7:0]    echo_s1;
	logic          open_s1;
	logic          go_s1;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_open_q;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign go_s1     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = !running || (valid_s1 && !go_s1);

	cbc_map u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.cmd         (cmd),
		.address     (address),
		.load_offset (load_offset),
		.write_data  (write_data),
		.req         (req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cbc_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbc_pkg::ST_CLEAR: begin
				if (clr_cnt_q == cbc_pkg::CLEAR_LAST) begin
					state_d = cbc_pkg::ST_RUN;
				end
			end
			default: begin
				state_d = cbc_pkg::ST_RUN;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			cbc_pkg::ST_CLEAR: begin
				running = 1'b0;
				clr_we  = 1'b1;
			end
			default: begin
				running = 1'b1;
				clr_we  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && req.rom_wr) begin
			rom_mem[req.rom_addr] <= req.echo_data;
		end
		if (accept && req.rom_rd) begin
			rom_rdata_s1 <= rom_mem[req.rom_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_we) begin
			ram_mem[clr_cnt_q] <= 8'h00;
		end else if (accept && req.ram_wr) begin
			ram_mem[req.ram_addr] <= req.echo_data;
		end
		if (accept && req.ram_rd) begin
			ram_rdata_s1 <= ram_mem[req.ram_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1  <= req.src;
			echo_s1 <= req.echo_data;
			open_s1 <= req.open;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			out_open_q <= open_s1;
			case (src_s1)
				cbc_pkg::SRC_ROM: out_data_q <= rom_rdata_s1;
				cbc_pkg::SRC_RAM: out_data_q <= ram_rdata_s1;
				default:          out_data_q <= echo_s1;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;
	assign open_bus  = out_open_q;

endmodule
`default_nettype wire

/* design/cbc_checker.sv */
// Port-level checks of the cartridge bank controller and their binding.
`default_nettype none
module cbc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [7:0]                      read_data,
	input wire logic                            open_bus
);

	// An open-bus beat always carries the open-bus byte.
	a_open_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && open_bus) |-> (read_data == cbc_pkg::OPEN_BUS))
	else $error("open-bus beat without open-bus byte");

	// A stalled result beat stays and holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(read_data) && $stable(open_bus)))
	else $error("stalled result beat changed");

	// The input side is stalled once reset has been seen low, as the RAM clearing pass starts.
	a_reset_stall: assert property (@(posedge clk)
		!arst_n |=> in_stall)
	else $error("input accepted during RAM clear");

endmodule

bind cartridge_bank_controller_core cbc_checker u_cbc_checker (.*);
`default_nettype wire
